@@ hw/rtl/adda_pkg.sv @@
// Shared types and constants for the averaged deviation duty accumulator.
package adda_pkg;

    // Field widths
    localparam int SAMPLE_W     = 12;
    localparam int SUM_W        = 20;
    localparam int MID_W        = 16;
    localparam int THR_W        = 16;
    localparam int GAIN_W       = 10;
    localparam int DECAY_W      = 13;
    localparam int DUTY_OUT_W   = 13;
    localparam int AVG_W        = 16;
    localparam int AVG_FRAC     = 4;
    localparam int GAIN_SHIFT   = 12;
    localparam int GPROD_W      = AVG_W + GAIN_W;
    localparam int ADD_W        = GPROD_W - GAIN_SHIFT;

    // Reciprocal used for the divide by the block length
    localparam int RECIP_SHIFT  = SUM_W + AVG_FRAC;
    localparam int RECIP_W      = RECIP_SHIFT + 1;
    localparam int EST_SHIFT    = RECIP_SHIFT - AVG_FRAC;

    // Stream and config port widths
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // Result queue
    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIDPOINT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 2'd3;

    // Register reset values
    localparam logic [MID_W-1:0]   MIDPOINT_RST  = 16'd29782;
    localparam logic [THR_W-1:0]   THRESHOLD_RST = 16'd993;
    localparam logic [GAIN_W-1:0]  GAIN_RST      = 10'd282;
    localparam logic [DECAY_W-1:0] DECAY_RST     = 13'd41;

    typedef struct packed {
        logic [MID_W-1:0]   midpoint_level;
        logic [THR_W-1:0]   movement_threshold;
        logic [GAIN_W-1:0]  sensitivity_gain;
        logic [DECAY_W-1:0] decay_step;
    } adda_cfg_t;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
    } adda_block_t;

    typedef struct packed {
        logic                  movement_seen;
        logic [DUTY_OUT_W-1:0] duty_value;
    } adda_result_t;

endpackage

@@ hw/rtl/averaged_deviation_duty_accumulator.sv @@
// Top level: block-averaged deviation detector driving a decaying duty level.
//
//  channel   dir  beat fields (low bit first)          handshake
//  s_*       in   tdata: adc_sample[11:0]               tvalid/tready
//  m_*       out  tdata: duty_value[12:0], moved[13]    tvalid/tready
//  cfg_*     in   index 0..3, wdata[15:0]               cfg_we, no wait
//
//  One sample is taken every cycle while s_tready is high.
//  A finished block passes the handoff register and the divide, deviation
//  and gain stages; its duty result then waits in the queue for the sink.
//  s_tready is a compare on a registered count: it drops only when the 8-entry result
//  queue plus the results already in the pipeline reach its depth.
//  Reset clears counters, duty level and valids; config returns to defaults.
module averaged_deviation_duty_accumulator #(
    parameter int SAMPLES_PER_BLOCK = 50,
    parameter int DUTY_BITS         = 13
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Sample stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [adda_pkg::S_TDATA_W-1:0]    s_tdata,   // [11:0] adc_sample
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [adda_pkg::M_TDATA_W-1:0]    m_tdata,   // [12:0] duty_value, [13] movement_seen
    // Config writes
    input  logic                              cfg_we,
    input  logic [adda_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [adda_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import adda_pkg::*;

    adda_cfg_t               cfg_reg;
    logic                    s_accept;
    logic                    m_accept;
    logic                    block_last;
    adda_block_t             blk;
    logic                    res_valid;
    adda_result_t            res;
    adda_result_t            out_res;
    logic                    out_valid;
    logic [FIFO_CNT_W-1:0]   reserve_reg;
    logic                    reserve_inc;

    assign s_accept    = s_tvalid && s_tready;
    assign m_accept    = m_tvalid && m_tready;
    assign reserve_inc = s_accept && block_last;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.midpoint_level     <= MIDPOINT_RST;
            cfg_reg.movement_threshold <= THRESHOLD_RST;
            cfg_reg.sensitivity_gain   <= GAIN_RST;
            cfg_reg.decay_step         <= DECAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIDPOINT:  cfg_reg.midpoint_level     <= cfg_wdata[MID_W-1:0];
                REG_THRESHOLD: cfg_reg.movement_threshold <= cfg_wdata[THR_W-1:0];
                REG_GAIN:      cfg_reg.sensitivity_gain   <= cfg_wdata[GAIN_W-1:0];
                REG_DECAY:     cfg_reg.decay_step         <= cfg_wdata[DECAY_W-1:0];
                default: ;
            endcase
        end
    end

    // Queue slots reserved by blocks in flight or waiting in the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            reserve_reg <= '0;
        else if (reserve_inc && !m_accept)
            reserve_reg <= reserve_reg + FIFO_CNT_W'(1);
        else if (m_accept && !reserve_inc)
            reserve_reg <= reserve_reg - FIFO_CNT_W'(1);
    end

    assign s_tready = (reserve_reg < FIFO_CNT_W'(FIFO_DEPTH));

    adda_block_accum #(
        .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK)
    ) u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (s_accept),
        .sample       (s_tdata[SAMPLE_W-1:0]),
        .block_last   (block_last),
        .blk          (blk)
    );

    adda_datapath #(
        .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK),
        .DUTY_BITS         (DUTY_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .blk       (blk),
        .res_valid (res_valid),
        .res       (res)
    );

    adda_result_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (res_valid),
        .wr_data  (res),
        .rd_en    (m_accept),
        .rd_valid (out_valid),
        .rd_data  (out_res)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = M_TDATA_W'(out_res);

`ifndef SYNTHESIS
    a_reserve_bound: assert property (@(posedge clk) disable iff (!rst_n)
        reserve_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("reserved result slots exceed queue depth");
    a_out_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (reserve_reg != '0))
        else $error("result offered without a reserved slot");
`endif

endmodule

@@ hw/rtl/adda_block_accum.sv @@
// Running sample sum and block counter; hands off each finished block sum.
module adda_block_accum #(
    parameter int SAMPLES_PER_BLOCK = 50
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    input  logic [adda_pkg::SAMPLE_W-1:0]  sample,
    output logic                           block_last,
    output adda_pkg::adda_block_t          blk
);
    import adda_pkg::*;

    localparam int CNT_W = $clog2(SAMPLES_PER_BLOCK + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_BLOCK - 1);

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0] count_reg;
    logic             blk_valid_reg;
    logic [SUM_W-1:0] blk_sum_reg;

    assign block_last = (count_reg == LAST_CNT);
    assign sum_next   = sum_reg + SUM_W'(sample);

    // Sum and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (sample_valid)
        begin
            if (block_last)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                sum_reg   <= sum_next;
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    // Block handoff valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            blk_valid_reg <= 1'b0;
        else
            blk_valid_reg <= sample_valid && block_last;
    end

    // Block sum payload
    always_ff @(posedge clk)
    begin
        if (sample_valid && block_last)
            blk_sum_reg <= sum_next;
    end

    assign blk.valid = blk_valid_reg;
    assign blk.sum   = blk_sum_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LAST_CNT)
        else $error("sample count ran past the block length");
`endif

endmodule

@@ hw/rtl/adda_datapath.sv @@
// Block average, deviation, gain and duty update pipeline.
module adda_datapath #(
    parameter int SAMPLES_PER_BLOCK = 50,
    parameter int DUTY_BITS         = 13
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  adda_pkg::adda_cfg_t    cfg,
    input  adda_pkg::adda_block_t  blk,
    output logic                   res_valid,
    output adda_pkg::adda_result_t res
);
    import adda_pkg::*;

    localparam int N_W      = $clog2(SAMPLES_PER_BLOCK + 1);
    localparam int PROD1_W  = SUM_W + RECIP_W;
    localparam int PROD2_W  = AVG_W + N_W;
    localparam int SCALED_W = SUM_W + AVG_FRAC;
    localparam int REM_W    = SCALED_W + 1;
    localparam int DSUM_W   = ((DUTY_BITS > ADD_W) ? DUTY_BITS : ADD_W) + 1;
    localparam int CMP_W    = (DUTY_BITS > DECAY_W) ? DUTY_BITS : DECAY_W;

    localparam logic [RECIP_W-1:0]   RECIP    =
        RECIP_W'((64'd1 << RECIP_SHIFT) / SAMPLES_PER_BLOCK);
    localparam logic [N_W-1:0]       BLK_N    = N_W'(SAMPLES_PER_BLOCK);
    localparam logic [REM_W-1:0]     BLK_N_R  = REM_W'(SAMPLES_PER_BLOCK);
    localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;

    // Stage: quotient estimate
    logic [PROD1_W-1:0]   prod1;
    logic                 est_valid_reg;
    logic [AVG_W-1:0]     est_q_reg;
    logic [SUM_W-1:0]     est_sum_reg;
    // Stage: corrected average
    logic [PROD2_W-1:0]   prod2;
    logic [SCALED_W-1:0]  scaled;
    logic [REM_W-1:0]     rem;
    logic [AVG_W-1:0]     avg_next;
    logic                 avg_valid_reg;
    logic [AVG_W-1:0]     avg_reg;
    // Stage: deviation
    logic [AVG_W-1:0]     dev_next;
    logic                 dev_valid_reg;
    logic [AVG_W-1:0]     dev_reg;
    logic                 dev_moved_reg;
    // Stage: duty increment
    logic [GPROD_W-1:0]   prod3;
    logic [ADD_W-1:0]     inc_next;
    logic                 inc_valid_reg;
    logic [ADD_W-1:0]     inc_reg;
    logic                 inc_moved_reg;
    // Duty update
    logic [DSUM_W-1:0]    dsum;
    logic [DUTY_BITS-1:0] duty_sat;
    logic [CMP_W-1:0]     duty_ext;
    logic [CMP_W-1:0]     decay_ext;
    logic [DUTY_BITS-1:0] duty_level_reg;
    logic [DUTY_BITS-1:0] duty_level_next;

    // sum*16/N estimate: at most one below the true quotient
    assign prod1 = PROD1_W'(blk.sum) * PROD1_W'(RECIP);

    // Correct the estimate with one compare
    assign prod2    = PROD2_W'(est_q_reg) * PROD2_W'(BLK_N);
    assign scaled   = {est_sum_reg, {AVG_FRAC{1'b0}}};
    assign rem      = REM_W'(scaled) - REM_W'(prod2);
    assign avg_next = est_q_reg + AVG_W'(rem >= BLK_N_R);

    // Absolute deviation from midpoint
    assign dev_next = (avg_reg >= cfg.midpoint_level) ? (avg_reg - cfg.midpoint_level)
                                                      : (cfg.midpoint_level - avg_reg);

    // Gain scaling
    assign prod3    = GPROD_W'(dev_reg) * GPROD_W'(cfg.sensitivity_gain);
    assign inc_next = dev_moved_reg ? prod3[GPROD_W-1:GAIN_SHIFT] : '0;

    // Saturating add, then decay with clamp
    assign dsum      = DSUM_W'(duty_level_reg) + DSUM_W'(inc_reg);
    assign duty_sat  = (dsum > DSUM_W'(DUTY_MAX)) ? DUTY_MAX : DUTY_BITS'(dsum);
    assign duty_ext  = CMP_W'(duty_sat);
    assign decay_ext = CMP_W'(cfg.decay_step);
    assign duty_level_next = (duty_ext > decay_ext) ? DUTY_BITS'(duty_ext - decay_ext) : '0;

    // Stage valids and duty state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_valid_reg  <= 1'b0;
            avg_valid_reg  <= 1'b0;
            dev_valid_reg  <= 1'b0;
            inc_valid_reg  <= 1'b0;
            duty_level_reg <= '0;
        end
        else
        begin
            est_valid_reg <= blk.valid;
            avg_valid_reg <= est_valid_reg;
            dev_valid_reg <= avg_valid_reg;
            inc_valid_reg <= dev_valid_reg;
            if (inc_valid_reg)
                duty_level_reg <= duty_level_next;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        est_q_reg     <= prod1[EST_SHIFT+AVG_W-1:EST_SHIFT];
        est_sum_reg   <= blk.sum;
        avg_reg       <= avg_next;
        dev_reg       <= dev_next;
        dev_moved_reg <= (dev_next > cfg.movement_threshold);
        inc_reg       <= inc_next;
        inc_moved_reg <= dev_moved_reg;
    end

    assign res_valid         = inc_valid_reg;
    assign res.duty_value    = duty_ext[DUTY_OUT_W-1:0];
    assign res.movement_seen = inc_moved_reg;

endmodule

@@ hw/rtl/adda_result_fifo.sv @@
// Small result queue that holds finished results until the sink takes them.
module adda_result_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  adda_pkg::adda_result_t wr_data,
    input  logic                   rd_en,
    output logic                   rd_valid,
    output adda_pkg::adda_result_t rd_data
);
    import adda_pkg::*;

    adda_result_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_CNT_W-1:0]   count_next;

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + FIFO_CNT_W'(1);
        else if (rd_en && !wr_en)
            count_next = count_reg - FIFO_CNT_W'(1);
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (count_reg != FIFO_CNT_W'(FIFO_DEPTH)) || rd_en)
        else $error("result queue written while full");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> (count_reg == $past(count_reg) + FIFO_CNT_W'(1)))
        else $error("result queue count did not follow a write");
`endif

endmodule
